@@ src/tsor_pkg.sv @@
// ----------------------------------------------------------------------------
// tsor_pkg
// Shared widths, command codes and control/status types for the
// timestamped overwrite ring.
// ----------------------------------------------------------------------------
`default_nettype none

package tsor_pkg;

  localparam int KIND_W           = 2;
  localparam int DATA_W           = 64;
  localparam int TIME_W           = 32;
  localparam int LIMIT_W          = 7;
  localparam int OCC_W            = 7;
  localparam int MAX_RESULTS      = 32;
  localparam int CNT_W            = $clog2(MAX_RESULTS + 1);
  localparam int DEF_CAPACITY     = 32;
  localparam int DEF_PAYLOAD_BITS = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH     = 2'd0,
    KIND_CULL     = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_SNAPSHOT = 2'd3
  } kind_e;

  typedef struct packed {
    logic push;
    logic clear;
    logic cull_start;
    logic cull_step;
    logic snap_start;
    logic load_entry;
    logic load_status;
  } tsor_cmd_t;

  typedef struct packed {
    logic cull_go;
    logic snap_zero;
    logic cnt_last;
    logic out_free;
  } tsor_sts_t;

endpackage

`default_nettype wire

@@ src/tsor_if.sv @@
// ----------------------------------------------------------------------------
// tsor_if
// Valid/ready channel interfaces: command input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsor_in_if import tsor_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [DATA_W-1:0]    point_data;
  logic [TIME_W-1:0]    point_time;
  logic [TIME_W-1:0]    cull_time;
  logic [LIMIT_W-1:0]   snapshot_limit;

  modport source (output valid, kind, point_data, point_time, cull_time,
                  snapshot_limit, input ready);
  modport sink   (input valid, kind, point_data, point_time, cull_time,
                  snapshot_limit, output ready);
endinterface

interface tsor_out_if import tsor_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    entry_data;
  logic [TIME_W-1:0]    entry_time;
  logic                 entry_valid;
  logic                 last;
  logic [OCC_W-1:0]     occupancy;
  logic                 is_empty;

  modport source (output valid, entry_data, entry_time, entry_valid, last,
                  occupancy, is_empty, input ready);
  modport sink   (input valid, entry_data, entry_time, entry_valid, last,
                  occupancy, is_empty, output ready);
endinterface

`default_nettype wire

@@ src/tsor_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsor_ctrl
// Command sequencer: takes one command beat at a time and steps the
// datapath through push, clear, cull walk, snapshot walk and status.
// ----------------------------------------------------------------------------
`default_nettype none

module tsor_ctrl import tsor_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [KIND_W-1:0] in_kind_i,
  output logic                   in_ready_o,
  input  wire tsor_sts_t         sts_i,
  output tsor_cmd_t              cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CULL,
    ST_SNAP,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_e'(in_kind_i))
            KIND_PUSH: begin
              cmd_o.push = 1'b1;
              state_d    = ST_RESP;
            end
            KIND_CULL: begin
              cmd_o.cull_start = 1'b1;
              state_d          = ST_CULL;
            end
            KIND_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d     = ST_RESP;
            end
            KIND_SNAPSHOT: begin
              if (sts_i.snap_zero) begin
                state_d = ST_RESP;
              end else begin
                cmd_o.snap_start = 1'b1;
                state_d          = ST_SNAP;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CULL: begin
        if (sts_i.cull_go) begin
          cmd_o.cull_step = 1'b1;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SNAP: begin
        if (sts_i.out_free) begin
          cmd_o.load_entry = 1'b1;
          if (sts_i.cnt_last) state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_status = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/tsor_dpath.sv @@
// ----------------------------------------------------------------------------
// tsor_dpath
// Ring storage, head/tail/walk pointers, snapshot counter and the output
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsor_dpath import tsor_pkg::*; #(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tsor_cmd_t          cmd_i,
  output tsor_sts_t               sts_o,
  input  wire logic [DATA_W-1:0]  point_data_i,
  input  wire logic [TIME_W-1:0]  point_time_i,
  input  wire logic [TIME_W-1:0]  cull_time_i,
  input  wire logic [LIMIT_W-1:0] snapshot_limit_i,
  tsor_out_if.source              out_o
);

  localparam int PTR_MOD = 2 * CAPACITY;
  localparam int PW      = $clog2(PTR_MOD);
  localparam int SW      = $clog2(CAPACITY);
  localparam int OW      = $clog2(CAPACITY + 1);
  localparam int EW      = PAYLOAD_BITS + TIME_W;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(PTR_MOD - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= PW'(CAPACITY)) ? p - PW'(CAPACITY) : p;
    return s[SW-1:0];
  endfunction

  logic [EW-1:0]      mem_q [CAPACITY];
  logic [EW-1:0]      rd_q;
  logic [PW-1:0]      head_q, head_d, tail_q, tail_d, walk_q, walk_d;
  logic [TIME_W-1:0]  ctime_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PW:0]        diff;
  logic [OW-1:0]      occ;
  logic               full;
  logic [LIMIT_W-1:0] occ_l, snap_m;
  logic [CNT_W-1:0]   snap_n;
  logic [DATA_W-1:0]  rd_data_ext;
  logic [TIME_W-1:0]  rd_time;

  logic               ovalid_q, ovalid_d;
  logic [DATA_W-1:0]  odata_q;
  logic [TIME_W-1:0]  otime_q;
  logic               oentry_q, olast_q;
  logic [OCC_W-1:0]   oocc_q;
  logic               oempty_q;

  // occupancy = (tail - head) mod 2*CAPACITY
  always_comb begin
    if (tail_q >= head_q) begin
      diff = {1'b0, tail_q} - {1'b0, head_q};
    end else begin
      diff = {1'b0, tail_q} + (PW+1)'(PTR_MOD) - {1'b0, head_q};
    end
    occ  = diff[OW-1:0];
    full = (occ == OW'(CAPACITY));
  end

  always_comb begin
    occ_l  = LIMIT_W'(occ);
    snap_m = (snapshot_limit_i < occ_l) ? snapshot_limit_i : occ_l;
    if (snap_m > LIMIT_W'(MAX_RESULTS)) snap_m = LIMIT_W'(MAX_RESULTS);
    snap_n = snap_m[CNT_W-1:0];
  end

  assign rd_time = rd_q[EW-1 -: TIME_W];

  always_comb begin
    rd_data_ext                   = '0;
    rd_data_ext[PAYLOAD_BITS-1:0] = rd_q[PAYLOAD_BITS-1:0];
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    walk_d = walk_q;
    cnt_d  = cnt_q;
    if (cmd_i.push) begin
      tail_d = ptr_next(tail_q);
      if (full) head_d = ptr_next(head_q);
    end
    if (cmd_i.clear) head_d = tail_q;
    if (cmd_i.cull_start || cmd_i.snap_start) walk_d = head_q;
    if (cmd_i.snap_start) cnt_d = snap_n;
    if (cmd_i.cull_step) begin
      head_d = ptr_next(head_q);
      walk_d = ptr_next(walk_q);
    end
    if (cmd_i.load_entry) begin
      walk_d = ptr_next(walk_q);
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_comb begin
    sts_o.cull_go   = (head_q != tail_q) && (rd_time < ctime_q);
    sts_o.snap_zero = (snap_n == '0);
    sts_o.cnt_last  = (cnt_q == CNT_W'(1));
    sts_o.out_free  = !ovalid_q || out_o.ready;
  end

  // Ring storage; read data is registered from walk_d, so rd_q tracks walk_q.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[ptr_slot(tail_q)] <= {point_time_i, point_data_i[PAYLOAD_BITS-1:0]};
    end
    rd_q <= mem_q[ptr_slot(walk_d)];
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (out_o.ready) ovalid_d = 1'b0;
    if (cmd_i.load_entry || cmd_i.load_status) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q <= walk_d;
    cnt_q  <= cnt_d;
    if (cmd_i.cull_start) ctime_q <= cull_time_i;
    if (cmd_i.load_entry) begin
      odata_q  <= rd_data_ext;
      otime_q  <= rd_time;
      oentry_q <= 1'b1;
      olast_q  <= (cnt_q == CNT_W'(1));
      oocc_q   <= OCC_W'(occ);
      oempty_q <= (occ == '0);
    end else if (cmd_i.load_status) begin
      odata_q  <= '0;
      otime_q  <= '0;
      oentry_q <= 1'b0;
      olast_q  <= 1'b1;
      oocc_q   <= OCC_W'(occ);
      oempty_q <= (occ == '0);
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.entry_data  = odata_q;
  assign out_o.entry_time  = otime_q;
  assign out_o.entry_valid = oentry_q;
  assign out_o.last        = olast_q;
  assign out_o.occupancy   = oocc_q;
  assign out_o.is_empty    = oempty_q;

endmodule

`default_nettype wire

@@ src/timestamped_overwrite_ring_core.sv @@
// ----------------------------------------------------------------------------
// timestamped_overwrite_ring_core
// Overwriting ring of timestamped entries with push, cull, clear and
// snapshot commands.
//
//   channel  dir  handshake     beat contents
//   in_i     in   valid/ready   kind, point_data, point_time, cull_time,
//                               snapshot_limit
//   out_o    out  valid/ready   entry_data, entry_time, entry_valid, last,
//                               occupancy, is_empty
//
// One command at a time. Push, clear and an empty snapshot end in a
// status beat. Cull: one store read per dropped entry, then a status beat.
// Snapshot of n entries: one store read per emitted beat. A full output
// register adds stall cycles; a new command is taken while the last result
// still waits. Reset clears head, tail and output valid; no store sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_overwrite_ring_core import tsor_pkg::*; #(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tsor_in_if.sink    in_i,
  tsor_out_if.source out_o
);

  tsor_cmd_t cmd;
  tsor_sts_t sts;
  logic      in_ready;

  assign in_i.ready = in_ready;

  tsor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tsor_dpath #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .point_data_i     (in_i.point_data),
    .point_time_i     (in_i.point_time),
    .cull_time_i      (in_i.cull_time),
    .snapshot_limit_i (in_i.snapshot_limit),
    .out_o            (out_o)
  );

endmodule

`default_nettype wire

@@ src/tsor_checker.sv @@
// ----------------------------------------------------------------------------
// tsor_checker
// Port-level checks on the ring's result stream, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module tsor_checker import tsor_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [DATA_W-1:0]  entry_data,
  input wire logic [TIME_W-1:0]  entry_time,
  input wire logic               entry_valid,
  input wire logic               last,
  input wire logic [OCC_W-1:0]   occupancy,
  input wire logic               is_empty
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(entry_data) &&
    $stable(entry_time) && $stable(entry_valid) && $stable(last))
    else $error("result beat changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !entry_valid |-> last && entry_data == '0 && entry_time == '0)
    else $error("status beat not last or carries data");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (is_empty == (occupancy == '0)))
    else $error("is_empty disagrees with occupancy");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> occupancy <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_entry_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && entry_valid |-> !is_empty)
    else $error("entry beat from an empty ring");

endmodule

bind timestamped_overwrite_ring_core tsor_checker #(.CAPACITY(CAPACITY)) u_tsor_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .entry_data  (out_o.entry_data),
  .entry_time  (out_o.entry_time),
  .entry_valid (out_o.entry_valid),
  .last        (out_o.last),
  .occupancy   (out_o.occupancy),
  .is_empty    (out_o.is_empty)
);

`default_nettype wire

@@ tb/timestamped_overwrite_ring_core_test.sv @@
// ----------------------------------------------------------------------------
// timestamped_overwrite_ring_core_test
// Self-checking bench for the overwriting timestamped ring. Commands go in
// over the input channel with random gaps. A scoreboard keeps its own copy
// of the ring and predicts every result beat. Beats taken from the output
// channel, under random and long receiver stalls, are checked field by
// field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_overwrite_ring_core_test import tsor_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH   = DEF_CAPACITY;
  localparam int PTR_WRAP     = 2 * RING_DEPTH;
  localparam int RANDOM_ITEMS = 340;
  localparam int HOLD_AT_BEAT = 150;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    kind_e              kind;
    logic [DATA_W-1:0]  point_data;
    logic [TIME_W-1:0]  point_time;
    logic [TIME_W-1:0]  cull_time;
    logic [LIMIT_W-1:0] snapshot_limit;
  } command_t;

  typedef struct {
    logic [DATA_W-1:0] entry_data;
    logic [TIME_W-1:0] entry_time;
    logic              entry_valid;
    logic              last;
    logic [OCC_W-1:0]  occupancy;
    logic              is_empty;
  } beat_t;

  class ring_scoreboard;
    logic [DATA_W-1:0] payloads[RING_DEPTH];
    logic [TIME_W-1:0] stamps[RING_DEPTH];
    int unsigned       head;
    int unsigned       tail;
    beat_t             awaited[$];
    int                errors;

    function int unsigned fill();
      return (tail + PTR_WRAP - head) % PTR_WRAP;
    endfunction

    function int unsigned bump(int unsigned p);
      return (p + 1) % PTR_WRAP;
    endfunction

    function void add_beat(logic [DATA_W-1:0] d, logic [TIME_W-1:0] t, logic v,
                           logic l);
      beat_t b;
      b.entry_data  = d;
      b.entry_time  = t;
      b.entry_valid = v;
      b.last        = l;
      b.occupancy   = OCC_W'(fill());
      b.is_empty    = (fill() == 0);
      awaited.push_back(b);
    endfunction

    function void note_command(command_t c);
      bit          full;
      int unsigned n;
      int unsigned p;
      case (c.kind)
        KIND_PUSH: begin
          full = fill() >= RING_DEPTH;
          payloads[tail % RING_DEPTH] = c.point_data;
          stamps[tail % RING_DEPTH]   = c.point_time;
          tail = bump(tail);
          if (full) head = bump(head);
          add_beat('0, '0, 1'b0, 1'b1);
        end
        KIND_CULL: begin
          while (head != tail && stamps[head % RING_DEPTH] < c.cull_time)
            head = bump(head);
          add_beat('0, '0, 1'b0, 1'b1);
        end
        KIND_CLEAR: begin
          head = tail;
          add_beat('0, '0, 1'b0, 1'b1);
        end
        default: begin
          n = fill();
          if (c.snapshot_limit < n) n = c.snapshot_limit;
          if (n > MAX_RESULTS) n = MAX_RESULTS;
          if (n == 0) begin
            add_beat('0, '0, 1'b0, 1'b1);
          end else begin
            p = head;
            for (int unsigned i = 0; i < n; i++) begin
              add_beat(payloads[p % RING_DEPTH], stamps[p % RING_DEPTH], 1'b1,
                       i + 1 == n);
              p = bump(p);
            end
          end
        end
      endcase
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result beat: data %h time %h", got.entry_data,
               got.entry_time);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.entry_data !== want.entry_data) begin
        $error("entry_data: expected %h, got %h", want.entry_data, got.entry_data);
        errors++;
      end
      if (got.entry_time !== want.entry_time) begin
        $error("entry_time: expected %h, got %h", want.entry_time, got.entry_time);
        errors++;
      end
      if (got.entry_valid !== want.entry_valid) begin
        $error("entry_valid: expected %b, got %b", want.entry_valid,
               got.entry_valid);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, got.last);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tsor_in_if  in_bus();
  tsor_out_if out_bus();

  timestamped_overwrite_ring_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  ring_scoreboard    sb = new();
  int                cmds_sent;
  int                beats_taken;
  bit                src_idle;
  bit                sink_idle;
  logic [TIME_W-1:0] time_base;

  always #5 clk_i = ~clk_i;

  // ---- command side ----

  task automatic send_cmd(input command_t c);
    int gap;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid          <= 1'b1;
    in_bus.kind           <= c.kind;
    in_bus.point_data     <= c.point_data;
    in_bus.point_time     <= c.point_time;
    in_bus.cull_time      <= c.cull_time;
    in_bus.snapshot_limit <= c.snapshot_limit;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.note_command(c);
    cmds_sent++;
  endtask

  task automatic wait_drained();
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 7'd64;
      1:       return LIMIT_W'($urandom_range(31, 33));
      2, 3, 4: return LIMIT_W'($urandom_range(0, 64));
      default: return LIMIT_W'($urandom_range(0, 8));
    endcase
  endfunction

  function automatic command_t any_cmd(kind_e k);
    command_t c;
    c.kind           = k;
    c.point_data     = {$urandom, $urandom};
    c.point_time     = $urandom;
    c.cull_time      = $urandom;
    c.snapshot_limit = pick_limit();
    return c;
  endfunction

  function automatic command_t push_cmd();
    command_t c;
    c = any_cmd(KIND_PUSH);
    if ($urandom_range(0, 7) != 0) begin
      time_base    = time_base + $urandom_range(1, 'h30000);
      c.point_time = time_base;
    end
    return c;
  endfunction

  function automatic command_t cull_cmd();
    command_t c;
    c = any_cmd(KIND_CULL);
    case ($urandom_range(0, 7))
      0:       c.cull_time = '0;
      1:       c.cull_time = '1;
      2:       c.cull_time = time_base + 1;
      3:       c.cull_time = $urandom;
      default: c.cull_time = time_base - $urandom_range(0, 'h100000);
    endcase
    return c;
  endfunction

  function automatic command_t fixed_cmd(kind_e k, logic [DATA_W-1:0] d,
                                         logic [TIME_W-1:0] pt,
                                         logic [TIME_W-1:0] ct,
                                         logic [LIMIT_W-1:0] lim);
    command_t c;
    c.kind           = k;
    c.point_data     = d;
    c.point_time     = pt;
    c.cull_time      = ct;
    c.snapshot_limit = lim;
    return c;
  endfunction

  task automatic run_directed();
    send_cmd(fixed_cmd(KIND_SNAPSHOT, '0, '0, '0, 7'd64));
    send_cmd(fixed_cmd(KIND_SNAPSHOT, '1, '1, '1, 7'd0));
    send_cmd(fixed_cmd(KIND_CULL, '0, '0, '1, 7'd0));
    send_cmd(fixed_cmd(KIND_CLEAR, '1, '1, '1, 7'd64));
    send_cmd(fixed_cmd(KIND_PUSH, '0, '0, '0, 7'd0));
    send_cmd(fixed_cmd(KIND_PUSH, '1, '1, '1, 7'd64));
    send_cmd(fixed_cmd(KIND_PUSH, 64'ha5a5_5a5a_0f0f_f0f0, 32'h0001_8000, '0,
                       7'd1));
    send_cmd(fixed_cmd(KIND_SNAPSHOT, '0, '0, '0, 7'd64));
    send_cmd(fixed_cmd(KIND_SNAPSHOT, '0, '0, '0, 7'd0));
    send_cmd(fixed_cmd(KIND_SNAPSHOT, '0, '0, '0, 7'd1));
    // head stamp equals cull time: nothing dropped
    send_cmd(fixed_cmd(KIND_CULL, '0, '0, '0, 7'd0));
    send_cmd(fixed_cmd(KIND_CULL, '0, '0, 32'h1, 7'd0));
    send_cmd(fixed_cmd(KIND_CULL, '0, '0, '1, 7'd0));
    send_cmd(fixed_cmd(KIND_SNAPSHOT, '0, '0, '0, 7'd2));
    send_cmd(fixed_cmd(KIND_CLEAR, '0, '0, '0, 7'd0));
    send_cmd(fixed_cmd(KIND_SNAPSHOT, '0, '0, '0, 7'd64));
    send_cmd(fixed_cmd(KIND_PUSH, 64'h1, 32'h0001_0000, '0, 7'd0));
    send_cmd(fixed_cmd(KIND_PUSH, 64'h2, 32'h0002_0000, '0, 7'd0));
    // cull everything
    send_cmd(fixed_cmd(KIND_CULL, '0, '0, '1, 7'd0));
    send_cmd(fixed_cmd(KIND_SNAPSHOT, '0, '0, '0, 7'd5));
  endtask

  task automatic run_episode(input bit overfill);
    int n;
    if (overfill) begin
      repeat (RING_DEPTH + $urandom_range(1, 10)) send_cmd(push_cmd());
      send_cmd(fixed_cmd(KIND_SNAPSHOT, '0, '0, '0, 7'd64));
      send_cmd(cull_cmd());
      send_cmd(any_cmd(KIND_SNAPSHOT));
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(1, 40);
        repeat (n) send_cmd(push_cmd());
        send_cmd(any_cmd(KIND_SNAPSHOT));
      end
      3, 4: begin
        n = $urandom_range(0, 12);
        repeat (n) send_cmd(push_cmd());
        send_cmd(cull_cmd());
        send_cmd(any_cmd(KIND_SNAPSHOT));
      end
      5: send_cmd(any_cmd(KIND_CLEAR));
      6: send_cmd(cull_cmd());
      7: send_cmd(any_cmd(kind_e'($urandom_range(0, 3))));
      default: send_cmd(push_cmd());
    endcase
  endtask

  initial begin
    bit paused;
    paused                = 1'b0;
    rst_ni                = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.kind           = KIND_PUSH;
    in_bus.point_data     = '0;
    in_bus.point_time     = '0;
    in_bus.cull_time      = '0;
    in_bus.snapshot_limit = '0;
    cmds_sent             = 0;
    src_idle              = 1'b1;
    time_base             = $urandom;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    in_bus.valid <= 1'b0;
    wait_drained();

    run_episode(1'b1);
    while (cmds_sent < RANDOM_ITEMS) begin
      if (!paused && cmds_sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        in_bus.valid <= 1'b0;
        wait_drained();
      end
      src_idle = ($urandom_range(0, 3) != 0);
      run_episode($urandom_range(0, 11) == 0);
    end
    in_bus.valid <= 1'b0;

    wait_drained();
    repeat (64) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---- result side ----

  initial begin
    int gap;
    out_bus.ready = 1'b0;
    beats_taken   = 0;
    sink_idle     = 1'b1;
    @(posedge rst_ni);
    forever begin
      gap = sink_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      beats_taken++;
      if (beats_taken % 40 == 0) sink_idle = ($urandom_range(0, 2) != 0);
      if (beats_taken == HOLD_AT_BEAT) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    beat_t b;
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      b.entry_data  = out_bus.entry_data;
      b.entry_time  = out_bus.entry_time;
      b.entry_valid = out_bus.entry_valid;
      b.last        = out_bus.last;
      b.occupancy   = out_bus.occupancy;
      b.is_empty    = out_bus.is_empty;
      sb.check_beat(b);
    end
  end

  initial begin
    #8ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ timestamped_overwrite_ring_core.f @@
src/tsor_pkg.sv
src/tsor_if.sv
src/tsor_ctrl.sv
src/tsor_dpath.sv
src/timestamped_overwrite_ring_core.sv
src/tsor_checker.sv
tb/timestamped_overwrite_ring_core_test.sv
